@@ hdl/brxf_pkg.sv @@
// Shared types and constants for the BACnet LLC receive frame filter.
package brxf_pkg;

    localparam int MAX_FRAME_LEN = 1514;
    localparam int POS_W = 11;
    localparam int MAC_W = 48;
    localparam int LEN_W = 16;
    localparam int LLC_HDR_LEN = 14;
    localparam int LLC_OVERHEAD = 3;
    localparam int MIN_LEN = 4;

    localparam int POS_LEN_HI = 12;
    localparam int POS_LEN_LO = 13;
    localparam int POS_DSAP = 14;
    localparam int POS_SSAP = 15;
    localparam int POS_CTRL = 16;
    localparam int POS_VERSION = 17;
    localparam int POS_PRIORITY = 18;
    localparam int POS_SRC_START = 6;

    localparam logic [7:0] LLC_SAP = 8'h82;
    localparam logic [7:0] LLC_CTRL = 8'h03;
    localparam logic [7:0] BACNET_VERSION = 8'h01;
    localparam logic [MAC_W-1:0] BCAST_MAC = {MAC_W{1'b1}};

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW = 2;
    localparam int QUEUE_CW = 3;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = MAC_W;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_MAC = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROMISCUOUS = 2'd1;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_end;
    } in_item_t;

    typedef struct packed {
        logic [7:0]       pdu_byte;
        logic             pdu_last;
        logic             short_frame;
        logic [MAC_W-1:0] source_mac;
        logic             dest_broadcast;
        logic [1:0]       net_priority;
    } out_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

@@ hdl/brxf_front.sv @@
// Front end: configuration registers, frame header parsing and PDU classification.
module brxf_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  brxf_pkg::in_item_t            s_item,
    input  logic                          cfg_we,
    input  logic [brxf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [brxf_pkg::CFG_DATA_W-1:0] cfg_data,
    input  brxf_pkg::queue_status_t       q_status,
    output logic                          push,
    output brxf_pkg::out_item_t           push_item
);

    logic [brxf_pkg::MAC_W-1:0] local_mac_reg;
    logic                       promiscuous_reg;

    logic [brxf_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [brxf_pkg::MAC_W-1:0] dest_reg, dest_next;
    logic [brxf_pkg::MAC_W-1:0] src_reg, src_next;
    logic [brxf_pkg::LEN_W-1:0] len_reg, len_next;
    logic                       rej_reg, rej_next;
    logic [brxf_pkg::POS_W-1:0] left_reg, left_next;
    logic [1:0]                 prio_reg, prio_next;
    logic                       done_reg, done_next;

    logic                       accept;
    logic                       emit;
    logic                       last_of_pdu;
    logic                       last;
    logic                       rej17;
    logic [brxf_pkg::POS_W-1:0] left_v;
    logic [brxf_pkg::LEN_W-1:0] len_pdu;
    logic [7:0]                 b;

    assign s_ready = !q_status.full;
    assign accept = s_valid && s_ready;
    assign b = s_item.rx_byte;
    assign len_pdu = len_reg - brxf_pkg::LEN_W'(brxf_pkg::LLC_OVERHEAD);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            local_mac_reg <= '0;
            promiscuous_reg <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                brxf_pkg::CFG_LOCAL_MAC: local_mac_reg <= cfg_data;
                brxf_pkg::CFG_PROMISCUOUS: promiscuous_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        pos_next = pos_reg;
        dest_next = dest_reg;
        src_next = src_reg;
        len_next = len_reg;
        rej_next = rej_reg;
        left_next = left_reg;
        prio_next = prio_reg;
        done_next = done_reg;
        emit = 1'b0;
        left_v = left_reg;
        rej17 = 1'b0;
        if (pos_reg < brxf_pkg::POS_W'(brxf_pkg::MAX_FRAME_LEN)) begin
            if (pos_reg < brxf_pkg::POS_W'(brxf_pkg::POS_SRC_START)) begin
                dest_next = {dest_reg[brxf_pkg::MAC_W-9:0], b};
            end else if (pos_reg < brxf_pkg::POS_W'(brxf_pkg::POS_LEN_HI)) begin
                src_next = {src_reg[brxf_pkg::MAC_W-9:0], b};
            end else if (pos_reg == brxf_pkg::POS_W'(brxf_pkg::POS_LEN_HI)) begin
                len_next = {b, 8'h00};
            end else if (pos_reg == brxf_pkg::POS_W'(brxf_pkg::POS_LEN_LO)) begin
                len_next = {len_reg[15:8], b};
                if (len_next < brxf_pkg::LEN_W'(brxf_pkg::MIN_LEN) ||
                    len_next > brxf_pkg::LEN_W'(brxf_pkg::MAX_FRAME_LEN -
                                                 brxf_pkg::LLC_HDR_LEN)) begin
                    rej_next = 1'b1;
                end
            end else if (pos_reg == brxf_pkg::POS_W'(brxf_pkg::POS_DSAP) ||
                         pos_reg == brxf_pkg::POS_W'(brxf_pkg::POS_SSAP)) begin
                if (b != brxf_pkg::LLC_SAP) begin
                    rej_next = 1'b1;
                end
            end else if (pos_reg == brxf_pkg::POS_W'(brxf_pkg::POS_CTRL)) begin
                if (b != brxf_pkg::LLC_CTRL) begin
                    rej_next = 1'b1;
                end
            end else if (pos_reg == brxf_pkg::POS_W'(brxf_pkg::POS_VERSION)) begin
                rej17 = rej_reg || (b != brxf_pkg::BACNET_VERSION) ||
                        (!promiscuous_reg && dest_reg != local_mac_reg &&
                         dest_reg != brxf_pkg::BCAST_MAC);
                rej_next = rej17;
                if (!rej17) begin
                    left_v = len_pdu[brxf_pkg::POS_W-1:0];
                    emit = 1'b1;
                end
            end else begin
                if (pos_reg == brxf_pkg::POS_W'(brxf_pkg::POS_PRIORITY)) begin
                    prio_next = b[1:0];
                end
                if (!rej_reg && !done_reg && left_reg != '0) begin
                    emit = 1'b1;
                end
            end
        end

        last_of_pdu = (left_v == brxf_pkg::POS_W'(1));
        last = last_of_pdu || s_item.frame_end;
        left_next = left_v;
        if (emit) begin
            left_next = left_v - brxf_pkg::POS_W'(1);
            if (last) begin
                done_next = 1'b1;
            end
        end

        if (s_item.frame_end) begin
            pos_next = '0;
            dest_next = '0;
            src_next = '0;
            len_next = '0;
            rej_next = 1'b0;
            left_next = '0;
            prio_next = '0;
            done_next = 1'b0;
        end else if (pos_reg < brxf_pkg::POS_W'(brxf_pkg::MAX_FRAME_LEN)) begin
            pos_next = pos_reg + brxf_pkg::POS_W'(1);
        end
    end

    always_comb begin
        push = accept && emit;
        push_item.pdu_byte = b;
        push_item.pdu_last = last;
        push_item.short_frame = s_item.frame_end && !last_of_pdu;
        push_item.source_mac = src_reg;
        push_item.dest_broadcast = (dest_reg == brxf_pkg::BCAST_MAC);
        push_item.net_priority = (pos_reg == brxf_pkg::POS_W'(brxf_pkg::POS_PRIORITY)) ?
                                 b[1:0] : prio_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            dest_reg <= '0;
            src_reg <= '0;
            len_reg <= '0;
            rej_reg <= 1'b0;
            left_reg <= '0;
            prio_reg <= '0;
            done_reg <= 1'b0;
        end else if (accept) begin
            pos_reg <= pos_next;
            dest_reg <= dest_next;
            src_reg <= src_next;
            len_reg <= len_next;
            rej_reg <= rej_next;
            left_reg <= left_next;
            prio_reg <= prio_next;
            done_reg <= done_next;
        end
    end

    a_no_emit_in_header: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> pos_reg >= brxf_pkg::POS_W'(brxf_pkg::POS_VERSION))
        else $error("PDU octet pushed from the frame header");
    a_no_emit_after_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && done_reg) |-> !push)
        else $error("PDU octet pushed after the PDU was closed");
    a_no_emit_rejected: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && rej_reg) |-> !push)
        else $error("PDU octet pushed for a rejected frame");

endmodule

@@ hdl/brxf_queue.sv @@
// Short result queue that decouples the parser from the output stage.
module brxf_queue (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  brxf_pkg::out_item_t     push_item,
    input  logic                    pop,
    output brxf_pkg::out_item_t     head_item,
    output brxf_pkg::queue_status_t q_status
);

    brxf_pkg::out_item_t               mem [brxf_pkg::QUEUE_DEPTH];
    logic [brxf_pkg::QUEUE_AW-1:0]     wr_ptr_reg;
    logic [brxf_pkg::QUEUE_AW-1:0]     rd_ptr_reg;
    logic [brxf_pkg::QUEUE_CW-1:0]     count_reg;

    assign q_status.full = (count_reg == brxf_pkg::QUEUE_CW'(brxf_pkg::QUEUE_DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign head_item = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + brxf_pkg::QUEUE_AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + brxf_pkg::QUEUE_AW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + brxf_pkg::QUEUE_CW'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - brxf_pkg::QUEUE_CW'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_status.full)
        else $error("Queue written while full");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_status.empty)
        else $error("Queue read while empty");
    a_count_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> count_reg == $past(count_reg) + brxf_pkg::QUEUE_CW'(1))
        else $error("Queue count lost a write");

endmodule

@@ hdl/brxf_back.sv @@
// Back end: registered output stage of the result channel.
module brxf_back (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  brxf_pkg::queue_status_t q_status,
    input  brxf_pkg::out_item_t     head_item,
    output logic                    pop,
    output logic                    m_valid,
    input  logic                    m_ready,
    output brxf_pkg::out_item_t     m_item
);

    logic                m_valid_reg;
    brxf_pkg::out_item_t m_item_reg;

    assign pop = !q_status.empty && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;
    assign m_item = m_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pop) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            m_item_reg <= head_item;
        end
    end

    a_stall_keeps_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !pop)
        else $error("Output register overwritten during a stall");
    a_refill_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (!q_status.empty && !m_valid_reg) |=> m_valid_reg)
        else $error("Output stage idle while the queue holds a result");
    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_status.empty && (!m_valid_reg || m_ready)) |=> !m_valid_reg)
        else $error("Output valid without a queued result");

endmodule

@@ hdl/bacnet_llc_rx_frame_filter.sv @@
// Top level of the BACnet 802.3 LLC receive frame filter.
//
// The s_ channel carries one received frame octet per transaction, with
// frame_end set on the last octet of the frame. Every octet is consumed;
// only octets of an accepted BACnet PDU (frame offset 17 onward) produce a
// transaction on the m_ channel, each tagged with the source MAC address,
// the broadcast flag and the network priority. Filtered frames vanish.
// The configuration port writes local_mac (index 0) or promiscuous (index 1);
// other indexes are ignored. Throughput is one octet per cycle on both
// channels while the queue is not full and the receiver does not stall.
// An accepted result is written to the result queue and then loaded into
// the output register that drives m_valid and m_item.
// When the receiver stalls, results collect in a four-entry queue; s_ready
// drops only while that queue is full, so the parser and output stage
// stall independently. Synchronous reset clears the frame state, the
// queue and both configuration registers; no clearing pass is needed.
module bacnet_llc_rx_frame_filter (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  brxf_pkg::in_item_t              s_item,
    output logic                            m_valid,
    input  logic                            m_ready,
    output brxf_pkg::out_item_t             m_item,
    input  logic                            cfg_we,
    input  logic [brxf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [brxf_pkg::CFG_DATA_W-1:0] cfg_data
);

    brxf_pkg::queue_status_t q_status;
    brxf_pkg::out_item_t     push_item;
    brxf_pkg::out_item_t     head_item;
    logic                    push;
    logic                    pop;

    brxf_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_status  (q_status),
        .push      (push),
        .push_item (push_item)
    );

    brxf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .q_status  (q_status)
    );

    brxf_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_status  (q_status),
        .head_item (head_item),
        .pop       (pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

endmodule
